// ===== rtl/smp_pkg.sv =====
// Shared types and constants for the square matrix power block.
// Holds register indexes, fixed register widths, parameter defaults and state enums.
// Used by smp_qmul and square_matrix_power.
package smp_pkg;

    // Parameter defaults.
    localparam int MAX_SIZE_DEF   = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register layout.
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int MATRIX_SIZE_W = 4;
    localparam int EXPONENT_W    = 8;
    localparam int STEP_W        = EXPONENT_W - 1;
    localparam int SIZE_CMP_W    = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT    = 1'b1;

    localparam logic [MATRIX_SIZE_W-1:0] MATRIX_SIZE_RESET = 4'd8;
    localparam logic [EXPONENT_W-1:0]    EXPONENT_RESET    = 8'd1;

    // Top-level sequencer.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_RD,
        ST_MUL,
        ST_WAIT,
        ST_OUT_RD,
        ST_OUT_SHOW
    } sq_state_t;

    // Source of the streamed result.
    typedef enum logic [1:0] {
        OM_ERR,
        OM_IDENT,
        OM_BASE,
        OM_PROD
    } out_mode_t;

    // Fixed-point multiplier sequencer.
    typedef enum logic [1:0] {
        QM_IDLE,
        QM_MUL,
        QM_DRAIN,
        QM_SCALE
    } qm_state_t;

endpackage

// ===== rtl/smp_qmul.sv =====
// Iterative signed fixed-point multiplier: four half-width partial products on one
// multiplier, then scaling by FRAC_BITS with floor rounding and saturation.
// Depends on smp_pkg.
module smp_qmul #(
    parameter int DATA_WIDTH = smp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = smp_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] q
);
    import smp_pkg::*;

    localparam int H  = (DATA_WIDTH + 1) / 2;
    localparam int MW = 2 * H;
    localparam int PW = 4 * H;

    localparam logic [PW-1:0] FRAC_MASK = (PW'(1) << FRAC_BITS) - PW'(1);
    localparam logic [PW-1:0] POS_LIM   = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
    localparam logic [PW-1:0] NEG_LIM   = PW'(1) << (DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    qm_state_t state_reg, state_next;

    logic [MW-1:0]         a_mag_reg, b_mag_reg;
    logic                  neg_reg;
    logic [MW-1:0]         pp_reg;
    logic [1:0]            pp_sel_reg;
    logic [1:0]            cnt_reg;
    logic [PW-1:0]         prod_reg;
    logic [DATA_WIDTH-1:0] q_reg;
    logic                  done_reg;

    logic                  load_ops, issue, add_en, scale_en;
    logic [DATA_WIDTH-1:0] a_abs, b_abs;
    logic [H-1:0]          a_half, b_half;
    logic [MW-1:0]         pp_next;
    logic [PW-1:0]         pp_ext, pp_shifted;
    logic [PW-1:0]         ml, mlr;
    logic                  rem_nz;
    logic [PW-1:0]         neg_val;
    logic [DATA_WIDTH-1:0] q_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            QM_IDLE:  if (start) state_next = QM_MUL;
            QM_MUL:   if (cnt_reg == 2'd3) state_next = QM_DRAIN;
            QM_DRAIN: state_next = QM_SCALE;
            QM_SCALE: state_next = QM_IDLE;
            default:  state_next = QM_IDLE;
        endcase
    end

    always_comb
    begin
        load_ops = (state_reg == QM_IDLE) && start;
        issue    = (state_reg == QM_MUL);
        add_en   = (state_reg == QM_DRAIN) || ((state_reg == QM_MUL) && (cnt_reg != 2'd0));
        scale_en = (state_reg == QM_SCALE);
    end

    // Magnitudes as unsigned values; the most negative input maps to 2^(DATA_WIDTH-1).
    assign a_abs = a[DATA_WIDTH-1] ? (~a + DATA_WIDTH'(1)) : a;
    assign b_abs = b[DATA_WIDTH-1] ? (~b + DATA_WIDTH'(1)) : b;

    assign a_half  = cnt_reg[0] ? a_mag_reg[MW-1:H] : a_mag_reg[H-1:0];
    assign b_half  = cnt_reg[1] ? b_mag_reg[MW-1:H] : b_mag_reg[H-1:0];
    assign pp_next = MW'(a_half) * MW'(b_half);

    assign pp_ext = PW'(pp_reg);
    always_comb
    begin
        unique case (pp_sel_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd3:    pp_shifted = pp_ext << (2 * H);
            default: pp_shifted = pp_ext << H;
        endcase
    end

    // Negative products round toward minus infinity, so the magnitude rounds up.
    assign ml      = prod_reg >> FRAC_BITS;
    assign rem_nz  = |(prod_reg & FRAC_MASK);
    assign mlr     = ml + PW'(rem_nz);
    assign neg_val = ~mlr + PW'(1);

    always_comb
    begin
        if (neg_reg)
        begin
            if (mlr > NEG_LIM)
                q_next = VMIN;
            else
                q_next = neg_val[DATA_WIDTH-1:0];
        end
        else
        begin
            if (ml > POS_LIM)
                q_next = VMAX;
            else
                q_next = ml[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= QM_IDLE;
            cnt_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= scale_en;
            if (load_ops)
                cnt_reg <= 2'd0;
            else if (issue)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ops)
        begin
            a_mag_reg <= MW'(a_abs);
            b_mag_reg <= MW'(b_abs);
            neg_reg   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            prod_reg  <= '0;
        end
        else if (add_en)
            prod_reg <= prod_reg + pp_shifted;
        if (issue)
        begin
            pp_reg     <= pp_next;
            pp_sel_reg <= cnt_reg;
        end
        if (scale_en)
            q_reg <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ===== rtl/square_matrix_power.sv =====
// Square matrix power block: loads a matrix, raises it to a power and streams the result.
// Top level with the sequencer and the element memories; uses smp_qmul and smp_pkg.
//
// The block takes one matrix element per transaction in row-major order, one per cycle,
// until matrix_size squared elements are in. It then stalls its input, raises the matrix
// to the power in exponent and streams the result in row-major order with last on the
// final element. Exponent 0 gives the identity, 1 the matrix itself, and a negative
// exponent a single transaction with error and last set. Each power step beyond the
// first is n*n*n multiply-accumulates on one shared iterative multiplier, each a
// memory read, a multiplier start, the multiplier's partial-product and scaling steps
// and a saturating accumulate, and each result transaction is a memory read followed
// by showing the element. Arithmetic is signed fixed point with FRAC_BITS fraction bits;
// products round toward minus infinity and every product and sum saturates.
module square_matrix_power #(
    parameter int MAX_SIZE   = smp_pkg::MAX_SIZE_DEF,
    parameter int DATA_WIDTH = smp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = smp_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [smp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [smp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [DATA_WIDTH-1:0]        element,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [DATA_WIDTH-1:0]        result_element,
    output logic                                last,
    output logic                                error
);
    import smp_pkg::*;

    localparam int CELLS = MAX_SIZE * MAX_SIZE;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PA_W  = IDX_W + 1;
    localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SZ_W  = $clog2(MAX_SIZE + 1);
    localparam int SZ2_W = 2 * SZ_W;
    localparam int LC_W  = $clog2(CELLS + 1);

    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE  =
        (FRAC_BITS < DATA_WIDTH - 1) ? (DATA_WIDTH'(1) << FRAC_BITS) : VMAX;

    // Configuration.
    logic [MATRIX_SIZE_W-1:0] matrix_size_reg;
    logic signed [EXPONENT_W-1:0] exponent_reg;

    // Sequencer state and counters.
    sq_state_t state_reg, state_next;
    out_mode_t mode_reg, mode_next;
    logic [LC_W-1:0]   load_count_reg, load_count_next;
    logic [SZ_W-1:0]   n_reg, n_next;
    logic [CW-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0]  rb_reg, rb_next, kb_reg, kb_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              src_base_reg, src_base_next;
    logic              src_bank_reg, src_bank_next;
    logic              dst_bank_reg, dst_bank_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;

    // Memories with registered reads.
    logic [DATA_WIDTH-1:0] base_mem [CELLS];
    logic [DATA_WIDTH-1:0] prod_mem [2**PA_W];
    logic [DATA_WIDTH-1:0] base_rd_a_reg, base_rd_b_reg, prod_rd_reg;

    logic             in_acc, load_done;
    logic [SZ_W-1:0]  eff_size;
    logic [SZ2_W-1:0] cells_now;
    logic [LC_W-1:0]  count_inc;
    logic             i_last, j_last, k_last, step_done;
    logic [IDX_W-1:0] a_idx, b_idx, w_idx, rd_a_addr, rd_b_addr;
    logic [PA_W-1:0]  prod_rd_addr, prod_wr_addr;
    logic             rd_en, base_we, prod_we, q_start, q_done;
    logic [DATA_WIDTH-1:0] q;
    logic [DATA_WIDTH-1:0] mul_b;
    logic [DATA_WIDTH:0]   sum_wide;
    logic [DATA_WIDTH-1:0] sum_sat;
    logic [SZ_W-1:0]  n_m1;

    smp_qmul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_start),
        .a     (base_rd_a_reg),
        .b     (mul_b),
        .done  (q_done),
        .q     (q)
    );

    // Matrix size as used: zero counts as one, anything above the maximum is clamped.
    always_comb
    begin
        if (matrix_size_reg == '0)
            eff_size = SZ_W'(1);
        else if (SIZE_CMP_W'(matrix_size_reg) > SIZE_CMP_W'(MAX_SIZE))
            eff_size = SZ_W'(MAX_SIZE);
        else
            eff_size = SZ_W'(matrix_size_reg);
    end

    assign in_acc    = in_valid && !in_stall;
    assign cells_now = SZ2_W'(eff_size) * SZ2_W'(eff_size);
    assign count_inc = load_count_reg + LC_W'(1);
    assign load_done = SZ2_W'(count_inc) >= cells_now;

    assign n_m1   = n_reg - SZ_W'(1);
    assign i_last = SZ_W'(i_reg) == n_m1;
    assign j_last = SZ_W'(j_reg) == n_m1;
    assign k_last = SZ_W'(k_reg) == n_m1;
    assign step_done = i_last && j_last && k_last;

    assign a_idx = rb_reg + IDX_W'(k_reg);
    assign b_idx = kb_reg + IDX_W'(j_reg);
    assign w_idx = rb_reg + IDX_W'(j_reg);

    assign mul_b = src_base_reg ? base_rd_b_reg : prod_rd_reg;

    // Saturating accumulate of the latest product.
    assign sum_wide = {acc_reg[DATA_WIDTH-1], acc_reg} + {q[DATA_WIDTH-1], q};
    always_comb
    begin
        if (sum_wide[DATA_WIDTH] != sum_wide[DATA_WIDTH-1])
            sum_sat = sum_wide[DATA_WIDTH] ? VMIN : VMAX;
        else
            sum_sat = sum_wide[DATA_WIDTH-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_acc && load_done)
                    state_next = ST_SETUP;
            ST_SETUP:
            begin
                if (exponent_reg < 0)
                    state_next = ST_OUT_SHOW;
                else if (exponent_reg <= EXPONENT_W'(1))
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_RD;
            end
            ST_RD:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (q_done)
                begin
                    if (step_done && (steps_reg == STEP_W'(1)))
                        state_next = ST_OUT_RD;
                    else
                        state_next = ST_RD;
                end
            end
            ST_OUT_RD:
                state_next = ST_OUT_SHOW;
            ST_OUT_SHOW:
            begin
                if (!out_stall)
                    state_next = last ? ST_LOAD : ST_OUT_RD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Datapath control and counter updates.
    always_comb
    begin
        mode_next       = mode_reg;
        load_count_next = load_count_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rb_next         = rb_reg;
        kb_next         = kb_reg;
        steps_next      = steps_reg;
        src_base_next   = src_base_reg;
        src_bank_next   = src_bank_reg;
        dst_bank_next   = dst_bank_reg;
        acc_next        = acc_reg;
        base_we         = 1'b0;
        prod_we         = 1'b0;
        rd_en           = 1'b0;
        q_start         = 1'b0;
        rd_a_addr       = a_idx;
        rd_b_addr       = b_idx;
        prod_rd_addr    = {src_bank_reg, b_idx};
        prod_wr_addr    = {dst_bank_reg, w_idx};

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    base_we = 1'b1;
                    if (load_done)
                    begin
                        load_count_next = '0;
                        n_next          = eff_size;
                    end
                    else
                        load_count_next = count_inc;
                end
            end
            ST_SETUP:
            begin
                i_next        = '0;
                j_next        = '0;
                k_next        = '0;
                rb_next       = '0;
                kb_next       = '0;
                acc_next      = '0;
                src_base_next = 1'b1;
                dst_bank_next = 1'b0;
                steps_next    = STEP_W'(exponent_reg - EXPONENT_W'(1));
                if (exponent_reg < 0)
                    mode_next = OM_ERR;
                else if (exponent_reg == '0)
                    mode_next = OM_IDENT;
                else if (exponent_reg == EXPONENT_W'(1))
                    mode_next = OM_BASE;
                else
                    mode_next = OM_PROD;
            end
            ST_RD:
                rd_en = 1'b1;
            ST_MUL:
                q_start = 1'b1;
            ST_WAIT:
            begin
                if (q_done)
                begin
                    if (k_last)
                    begin
                        prod_we  = 1'b1;
                        acc_next = '0;
                        k_next   = '0;
                        kb_next  = '0;
                        if (j_last)
                        begin
                            j_next = '0;
                            if (i_last)
                            begin
                                // One full product is in; it becomes the next right operand.
                                i_next        = '0;
                                rb_next       = '0;
                                steps_next    = steps_reg - STEP_W'(1);
                                src_base_next = 1'b0;
                                src_bank_next = dst_bank_reg;
                                dst_bank_next = ~dst_bank_reg;
                            end
                            else
                            begin
                                i_next  = i_reg + CW'(1);
                                rb_next = rb_reg + IDX_W'(n_reg);
                            end
                        end
                        else
                            j_next = j_reg + CW'(1);
                    end
                    else
                    begin
                        acc_next = sum_sat;
                        k_next   = k_reg + CW'(1);
                        kb_next  = kb_reg + IDX_W'(n_reg);
                    end
                end
            end
            ST_OUT_RD:
            begin
                rd_en        = 1'b1;
                rd_a_addr    = w_idx;
                prod_rd_addr = {src_bank_reg, w_idx};
            end
            ST_OUT_SHOW:
            begin
                if (!out_stall && !last)
                begin
                    if (j_last)
                    begin
                        j_next  = '0;
                        i_next  = i_reg + CW'(1);
                        rb_next = rb_reg + IDX_W'(n_reg);
                    end
                    else
                        j_next = j_reg + CW'(1);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            mode_reg        <= OM_ERR;
            load_count_reg  <= '0;
            n_reg           <= SZ_W'(1);
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            rb_reg          <= '0;
            kb_reg          <= '0;
            steps_reg       <= '0;
            src_base_reg    <= 1'b1;
            src_bank_reg    <= 1'b0;
            dst_bank_reg    <= 1'b0;
            matrix_size_reg <= MATRIX_SIZE_RESET;
            exponent_reg    <= EXPONENT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            load_count_reg <= load_count_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            rb_reg         <= rb_next;
            kb_reg         <= kb_next;
            steps_reg      <= steps_next;
            src_base_reg   <= src_base_next;
            src_bank_reg   <= src_bank_next;
            dst_bank_reg   <= dst_bank_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_MATRIX_SIZE: matrix_size_reg <= cfg_data[MATRIX_SIZE_W-1:0];
                    REG_EXPONENT:    exponent_reg    <= cfg_data[EXPONENT_W-1:0];
                    default:         exponent_reg    <= exponent_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[load_count_reg[IDX_W-1:0]] <= element;
        if (rd_en)
        begin
            base_rd_a_reg <= base_mem[rd_a_addr];
            base_rd_b_reg <= base_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_we)
            prod_mem[prod_wr_addr] <= sum_sat;
        if (rd_en)
            prod_rd_reg <= prod_mem[prod_rd_addr];
    end

    // Output channel.
    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_OUT_SHOW);
    assign error     = (mode_reg == OM_ERR);
    assign last      = (mode_reg == OM_ERR) || (i_last && j_last);

    always_comb
    begin
        unique case (mode_reg)
            OM_ERR:   result_element = '0;
            OM_IDENT: result_element = (i_reg == j_reg) ? ONE : '0;
            OM_BASE:  result_element = base_rd_a_reg;
            OM_PROD:  result_element = prod_rd_reg;
            default:  result_element = '0;
        endcase
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        q_done |-> (state_reg == ST_WAIT))
        else $error("multiplier finished outside the accumulate wait");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (load_count_reg == '0))
        else $error("load count not cleared while the matrix is being processed");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> last)
        else $error("error transaction without last");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
        else $error("result stream continued after its last transaction");

endmodule

// ===== verif/square_matrix_power_tb.sv =====
// Self-checking testbench for square_matrix_power: loads matrices, raises them to powers and
// compares every streamed element with a planned value or an in-bench fixed-point power calculator.
// Depends on smp_pkg and the square_matrix_power RTL only.
module square_matrix_power_tb;
    import smp_pkg::*;

    localparam int DW    = DATA_WIDTH_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam int SIDE  = MAX_SIZE_DEF;
    localparam int CELLS = SIDE * SIDE;

    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 50;
    localparam int HOLD_CYCLES   = 2000;
    localparam int RANDOM_ITEMS  = 80;

    localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] Q_ONE = (FB < DW - 1) ? DW'(64'sd1 <<< FB) : Q_MAX;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 last;
        logic                 error;
    } powered_t;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 typed;
        powered_t             want;
    } load_item_t;

    typedef enum {ROW_WRITE, ROW_LOAD} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   data;
        load_item_t              item;
    } plan_row_t;

    typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [DW-1:0]   element;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [DW-1:0]   result_element;
    logic                   last;
    logic                   error;

    square_matrix_power dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .element        (element),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_element (result_element),
        .last           (last),
        .error          (error)
    );

    // Power calculator state: a private copy of the element stores and the registers.
    logic signed [DW-1:0]     base_m [CELLS];
    logic signed [DW-1:0]     prod_m [CELLS];
    logic signed [DW-1:0]     next_m [CELLS];
    int                       filled;
    logic [MATRIX_SIZE_W-1:0] size_reg;
    logic [EXPONENT_W-1:0]    exp_reg;

    powered_t   fresh[$];
    powered_t   powered_q[$];
    load_item_t load_q[$];
    plan_row_t  plan[$];

    powered_t seen_item;
    powered_t due_item;
    int       mismatch_count = 0;
    bit       hold_armed = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #24000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int side_in_use();
        int n;
        n = size_reg;
        if (n == 0)
            n = 1;
        if (n > SIDE)
            n = SIDE;
        return n;
    endfunction

    function automatic logic signed [DW-1:0] clamp_q(input longint x);
        if (x > longint'(Q_MAX))
            return Q_MAX;
        if (x < longint'(Q_MIN))
            return Q_MIN;
        return x[DW-1:0];
    endfunction

    // An arithmetic shift of the exact product floors it, which is the required rounding.
    function automatic logic signed [DW-1:0] fx_mul(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp_q(p >>> FB);
    endfunction

    // Takes one accepted element and leaves the result transactions it causes in fresh.
    function automatic void accept_element(input logic signed [DW-1:0] v);
        int n;
        int power;
        logic signed [DW-1:0] acc;
        fresh.delete();
        n = side_in_use();
        if (filled < CELLS)
            base_m[filled] = v;
        filled++;
        if (filled < n * n)
            return;
        filled = 0;
        power = int'($signed(exp_reg));
        if (power < 0)
        begin
            fresh.push_back(powered_t'{value: '0, last: 1'b1, error: 1'b1});
            return;
        end
        if (power == 0)
        begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    prod_m[i * n + j] = (i == j) ? Q_ONE : '0;
        end
        else
        begin
            prod_m = base_m;
            for (int s = 1; s < power; s++)
            begin
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < n; k++)
                            acc = clamp_q(longint'(acc) +
                                          longint'(fx_mul(base_m[i * n + k], prod_m[k * n + j])));
                        next_m[i * n + j] = acc;
                    end
                end
                prod_m = next_m;
            end
        end
        for (int i = 0; i < n * n; i++)
            fresh.push_back(powered_t'{value: prod_m[i], last: (i == n * n - 1), error: 1'b0});
    endfunction

    function automatic logic signed [DW-1:0] rand_element();
        int r;
        r = $urandom_range(0, 196608);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return '0;
                endcase
            end
            default: return r - 98304;
        endcase
    endfunction

    function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        row.item = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_load(input logic signed [DW-1:0] value, input bit typed = 1'b0,
                                      input powered_t want = '0);
        plan_row_t row;
        row.kind = ROW_LOAD;
        row.idx  = '0;
        row.data = '0;
        row.item = load_item_t'{value: value, typed: typed, want: want};
        plan.push_back(row);
    endfunction

    task automatic wait_idle();
        while (load_q.size() != 0 || powered_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_MATRIX_SIZE)
            size_reg = data[MATRIX_SIZE_W-1:0];
        else
            exp_reg = data[EXPONENT_W-1:0];
    endtask

    // Element sender: bursts of random length separated by random gaps.
    initial
    begin : sender
        int burst_left;
        int gap;
        load_item_t item;
        in_valid   = 1'b0;
        element    = '0;
        burst_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (load_q.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    gap        = $urandom_range(0, 6);
                    burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 12);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                item = load_q[0];
                in_valid <= 1'b1;
                element  <= item.value;
                do
                    @(posedge clk);
                while (in_stall);
                void'(load_q.pop_front());
                burst_left--;
                accept_element(item.value);
                if (item.typed)
                begin
                    powered_q.push_back(item.want);
                end
                else
                begin
                    foreach (fresh[i])
                        powered_q.push_back(fresh[i]);
                end
            end
        end
    end

    // Result receiver: stalls in changing modes, and once holds off long enough to back up
    // the block into its input.
    initial
    begin : receiver
        stall_mode_t mode;
        int mode_left;
        out_stall = 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_armed && out_valid)
            begin
                hold_armed = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_item = powered_t'{value: result_element, last: last, error: error};
            if (powered_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result transaction: value %h last %b error %b",
                             seen_item.value, seen_item.last, seen_item.error);
                mismatch_count++;
            end
            else
            begin
                due_item = powered_q.pop_front();
                if (seen_item.value !== due_item.value || seen_item.last !== due_item.last ||
                    seen_item.error !== due_item.error)
                begin
                    if (mismatch_count < 10)
                        $display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 due_item.value, due_item.last, due_item.error,
                                 seen_item.value, seen_item.last, seen_item.error);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int k;
        int count;
        int phase;
        int pick;
        int random_loaded;
        logic [3:0] hi_nib;
        logic [3:0] size_nib;
        logic [CFG_DATA_W-1:0] exp_byte;

        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        filled       = 0;
        size_reg     = MATRIX_SIZE_RESET;
        exp_reg      = EXPONENT_RESET;
        foreach (base_m[i])
        begin
            base_m[i] = '0;
            prod_m[i] = '0;
            next_m[i] = '0;
        end

        // Directed part: one-element matrices with results that are plain to see, then
        // saturation, a size cut during a load and an exponent change during a load.
        plan_write(REG_MATRIX_SIZE, 8'd1);
        plan_write(REG_EXPONENT, 8'd1);
        plan_load(32'sh7fffffff, 1'b1, powered_t'{value: 32'sh7fffffff, last: 1'b1, error: 1'b0});
        plan_load(32'sh80000000, 1'b1, powered_t'{value: 32'sh80000000, last: 1'b1, error: 1'b0});
        plan_load(32'sh00000000, 1'b1, powered_t'{value: 32'sh00000000, last: 1'b1, error: 1'b0});
        plan_write(REG_EXPONENT, 8'd0);
        plan_load(32'sh12345678, 1'b1, powered_t'{value: 32'sh00010000, last: 1'b1, error: 1'b0});
        plan_write(REG_EXPONENT, 8'h80);
        plan_load(32'shdeadbeef, 1'b1, powered_t'{value: 32'sh00000000, last: 1'b1, error: 1'b1});
        plan_write(REG_EXPONENT, 8'h7f);
        plan_load(32'sh00010000, 1'b1, powered_t'{value: 32'sh00010000, last: 1'b1, error: 1'b0});
        plan_load(32'sh00020000, 1'b1, powered_t'{value: 32'sh7fffffff, last: 1'b1, error: 1'b0});
        plan_load(32'shfffe0000);
        // Upper bits set and a size field of zero, which runs as a single element.
        plan_write(REG_MATRIX_SIZE, 8'hf0);
        plan_write(REG_EXPONENT, 8'd2);
        plan_load(32'sh00030000, 1'b1, powered_t'{value: 32'sh00090000, last: 1'b1, error: 1'b0});
        plan_load(32'shffff8000);
        plan_write(REG_MATRIX_SIZE, 8'd2);
        repeat (4) plan_load(32'sh7fffffff);
        plan_write(REG_MATRIX_SIZE, 8'd3);
        plan_write(REG_EXPONENT, 8'd1);
        for (int v = 1; v <= 5; v++)
            plan_load(v * 32'sh00010000);
        // Five elements are in; a 2x2 size makes the next element start the power at once.
        plan_write(REG_MATRIX_SIZE, 8'd2);
        plan_load(32'sh00060000);
        plan_write(REG_EXPONENT, 8'hff);
        plan_load(32'sh00008000);
        plan_load(32'shffff0000);
        plan_write(REG_EXPONENT, 8'd3);
        plan_load(32'sh00018000);
        plan_load(32'sh00004000);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(plan[r].idx, plan[r].data);
            end
            else
            begin
                load_q.push_back(plan[r].item);
            end
        end

        phase         = 0;
        random_loaded = 0;
        while (random_loaded < RANDOM_ITEMS)
        begin
            wait_idle();
            hi_nib = 4'($urandom_range(0, 15));
            pick   = $urandom_range(0, 19);
            if (phase == 0)
                size_nib = 4'd15;
            else if (phase == 1)
                size_nib = 4'd2;
            else if (pick == 0)
                size_nib = 4'd0;
            else if (pick == 1)
                size_nib = 4'($urandom_range(9, 15));
            else if (pick == 2)
                size_nib = 4'($urandom_range(5, 8));
            else
                size_nib = 4'($urandom_range(1, 4));
            write_reg(REG_MATRIX_SIZE, {hi_nib, size_nib});
            n = side_in_use();

            // Long powers only on tiny matrices, since each step costs n cubed products.
            pick = $urandom_range(0, 9);
            if (pick == 0)
                exp_byte = CFG_DATA_W'($urandom_range(128, 255));
            else if (pick == 1)
                exp_byte = CFG_DATA_W'((n == 1) ? $urandom_range(5, 127) :
                                       (n == 2) ? $urandom_range(5, 40) : $urandom_range(0, 3));
            else
                exp_byte = CFG_DATA_W'($urandom_range(0, (n > 4) ? 2 : 4));
            write_reg(REG_EXPONENT, exp_byte);

            k     = (phase == 1) ? 3 : (n > 4) ? 1 : $urandom_range(1, 3);
            count = k * n * n;
            if (phase != 0 && n > 1 && $urandom_range(0, 3) == 0)
                count += $urandom_range(1, n * n - 1);
            if (phase > 1 && count > RANDOM_ITEMS - random_loaded)
                count = RANDOM_ITEMS - random_loaded;
            if (phase == 1)
                hold_armed = 1'b1;
            repeat (count)
                load_q.push_back(load_item_t'{value: rand_element(), typed: 1'b0, want: '0});
            random_loaded += count;
            phase++;
        end

        wait_idle();
        repeat (END_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== square_matrix_power.f =====
rtl/smp_pkg.sv
rtl/smp_qmul.sv
rtl/square_matrix_power.sv
verif/square_matrix_power_tb.sv
